### rtl/core/mdsb_pkg.sv
// shared types, register codes and constants of the motor duty step and brake controller
package mdsb_pkg;

  localparam int SPEED_WIDTH_DEFAULT = 24;
  localparam int ERPM_W = 24;
  localparam int DUTY_W = 16;
  localparam int CUR_W = 16;
  localparam int STEP_W = 15;
  localparam int TRIG_W = 23;
  localparam int MS_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 23;

  localparam int DUTY_MAX = 32767;
  localparam int LARGE_PCT = 51;
  localparam int MEDIUM_PCT = 6;
  localparam int PCT_SCALE = 100;

  // actions
  localparam logic [1:0] ACT_SET_TARGET = 2'd0;
  localparam logic [1:0] ACT_BRAKE      = 2'd1;
  localparam logic [1:0] ACT_UPDATE     = 2'd2;
  localparam logic [1:0] ACT_TICK       = 2'd3;

  // command kinds
  localparam logic [1:0] KIND_DUTY    = 2'd0;
  localparam logic [1:0] KIND_CURRENT = 2'd1;
  localparam logic [1:0] KIND_BRAKE   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LARGE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd6;

  // register reset values
  localparam logic [STEP_W-1:0] LARGE_RST   = 15'd3277;
  localparam logic [STEP_W-1:0] MEDIUM_RST  = 15'd328;
  localparam logic [STEP_W-1:0] SMALL_RST   = 15'd33;
  localparam logic [CUR_W-1:0]  RAMP_RST    = 16'd100;
  localparam logic [CUR_W-1:0]  LIMIT_RST   = 16'd10000;
  localparam logic [TRIG_W-1:0] TRIGGER_RST = 23'd1000;
  localparam logic [MS_W-1:0]   TIMEOUT_RST = 16'd1000;

  typedef struct packed {
    logic [STEP_W-1:0] large_step;
    logic [STEP_W-1:0] medium_step;
    logic [STEP_W-1:0] small_step;
    logic [CUR_W-1:0]  ramp;
    logic [CUR_W-1:0]  limit;
    logic [TRIG_W-1:0] trigger;
    logic [MS_W-1:0]   timeout;
  } cfg_t;

  typedef struct packed {
    logic             braking;
    logic [CUR_W-1:0] brake_current;
    logic [MS_W-1:0]  elapsed;
    logic             expired;
  } ctl_state_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DUTY_W-1:0] duty;
    logic [CUR_W-1:0]  current;
  } cmd_t;

endpackage

### rtl/core/mdsb_regs.sv
// configuration register file
module mdsb_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mdsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mdsb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output mdsb_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.large_step  <= mdsb_pkg::LARGE_RST;
      cfg.medium_step <= mdsb_pkg::MEDIUM_RST;
      cfg.small_step  <= mdsb_pkg::SMALL_RST;
      cfg.ramp        <= mdsb_pkg::RAMP_RST;
      cfg.limit       <= mdsb_pkg::LIMIT_RST;
      cfg.trigger     <= mdsb_pkg::TRIGGER_RST;
      cfg.timeout     <= mdsb_pkg::TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mdsb_pkg::REG_LARGE:   cfg.large_step  <= cfg_data[mdsb_pkg::STEP_W-1:0];
        mdsb_pkg::REG_MEDIUM:  cfg.medium_step <= cfg_data[mdsb_pkg::STEP_W-1:0];
        mdsb_pkg::REG_SMALL:   cfg.small_step  <= cfg_data[mdsb_pkg::STEP_W-1:0];
        mdsb_pkg::REG_RAMP:    cfg.ramp        <= cfg_data[mdsb_pkg::CUR_W-1:0];
        mdsb_pkg::REG_LIMIT:   cfg.limit       <= cfg_data[mdsb_pkg::CUR_W-1:0];
        mdsb_pkg::REG_TRIGGER: cfg.trigger     <= cfg_data[mdsb_pkg::TRIG_W-1:0];
        mdsb_pkg::REG_TIMEOUT: cfg.timeout     <= cfg_data[mdsb_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/mdsb_eval.sv
// per-word decision logic: next control state and the command for an update
module mdsb_eval #(
  parameter int SPEED_WIDTH = mdsb_pkg::SPEED_WIDTH_DEFAULT
) (
  input  logic [1:0]                        action,
  input  logic signed [mdsb_pkg::ERPM_W-1:0] target_erpm,
  input  logic signed [mdsb_pkg::ERPM_W-1:0] measured_erpm,
  input  logic signed [mdsb_pkg::DUTY_W-1:0] present_duty,
  input  logic                              telemetry_ok,
  input  mdsb_pkg::cfg_t                    cfg,
  input  mdsb_pkg::ctl_state_t              st,
  input  logic signed [SPEED_WIDTH-1:0]     tgt,
  output mdsb_pkg::ctl_state_t              st_next,
  output logic signed [SPEED_WIDTH-1:0]     tgt_next,
  output logic                              has_result,
  output mdsb_pkg::cmd_t                    cmd
);

  localparam int XW = (SPEED_WIDTH > mdsb_pkg::ERPM_W) ? SPEED_WIDTH : mdsb_pkg::ERPM_W;
  localparam int W  = XW + 2;
  localparam int CW = W + 7;
  localparam int SW = mdsb_pkg::DUTY_W + 2;

  logic signed [XW-1:0]          tgt_wide;
  logic signed [W-1:0]           meas_x;
  logic signed [W-1:0]           tgt_x;
  logic signed [W-1:0]           diff;
  logic [W-1:0]                  err_mag;
  logic [W-1:0]                  tgt_mag;
  logic [CW-1:0]                 err_scaled;
  logic [CW-1:0]                 tgt_large;
  logic [CW-1:0]                 tgt_medium;
  logic [mdsb_pkg::ERPM_W-1:0]   meas_mag;
  logic                          below_trigger;
  logic [mdsb_pkg::CUR_W:0]      ramp_sum;
  logic [mdsb_pkg::CUR_W-1:0]    brake_next;
  logic [mdsb_pkg::STEP_W-1:0]   step;
  logic                          speed_up;
  logic signed [SW-1:0]          duty_sum;
  logic signed [SW-1:0]          duty_clamp;
  logic [mdsb_pkg::MS_W-1:0]     elapsed_inc;

  // sign-extend to the wider of both widths, then wrap to the stored width
  assign tgt_wide = XW'(target_erpm);

  assign meas_x = W'(measured_erpm);
  assign tgt_x  = W'(tgt);
  assign diff   = meas_x - tgt_x;
  assign err_mag = diff[W-1] ? W'(-diff) : W'(diff);
  assign tgt_mag = tgt_x[W-1] ? W'(-tgt_x) : W'(tgt_x);

  // relative error thresholds, 100|e| against 51|d| and 6|d|
  assign err_scaled = CW'(err_mag) * CW'(mdsb_pkg::PCT_SCALE);
  assign tgt_large  = CW'(tgt_mag) * CW'(mdsb_pkg::LARGE_PCT);
  assign tgt_medium = CW'(tgt_mag) * CW'(mdsb_pkg::MEDIUM_PCT);

  assign meas_mag = measured_erpm[mdsb_pkg::ERPM_W-1] ?
                    mdsb_pkg::ERPM_W'(-measured_erpm) : mdsb_pkg::ERPM_W'(measured_erpm);
  assign below_trigger = meas_mag < mdsb_pkg::ERPM_W'(cfg.trigger);

  assign ramp_sum   = {1'b0, st.brake_current} + {1'b0, cfg.ramp};
  assign brake_next = (ramp_sum > {1'b0, cfg.limit}) ? cfg.limit
                                                    : ramp_sum[mdsb_pkg::CUR_W-1:0];

  always_comb begin
    if (err_scaled >= tgt_large) begin
      step = cfg.large_step;
    end else if (err_scaled >= tgt_medium) begin
      step = cfg.medium_step;
    end else begin
      step = cfg.small_step;
    end
  end

  assign speed_up = meas_x < tgt_x;
  assign duty_sum = speed_up ? SW'(present_duty) + $signed(SW'(step))
                             : SW'(present_duty) - $signed(SW'(step));

  always_comb begin
    if (duty_sum > SW'(mdsb_pkg::DUTY_MAX)) begin
      duty_clamp = SW'(mdsb_pkg::DUTY_MAX);
    end else if (duty_sum < -SW'(mdsb_pkg::DUTY_MAX)) begin
      duty_clamp = -SW'(mdsb_pkg::DUTY_MAX);
    end else begin
      duty_clamp = duty_sum;
    end
  end

  // timer saturates at all ones
  assign elapsed_inc = (&st.elapsed) ? st.elapsed : st.elapsed + 1'b1;

  always_comb begin
    st_next    = st;
    tgt_next   = tgt;
    has_result = 1'b0;
    cmd        = '0;
    unique case (action)
      mdsb_pkg::ACT_SET_TARGET: begin
        tgt_next = tgt_wide[SPEED_WIDTH-1:0];
        st_next.braking = 1'b0;
        st_next.brake_current = '0;
        st_next.elapsed = '0;
        st_next.expired = 1'b0;
      end
      mdsb_pkg::ACT_BRAKE: begin
        st_next.braking = 1'b1;
      end
      mdsb_pkg::ACT_TICK: begin
        if (!st.expired) begin
          st_next.elapsed = elapsed_inc;
          if (elapsed_inc >= cfg.timeout) begin
            st_next.expired = 1'b1;
          end
        end
      end
      mdsb_pkg::ACT_UPDATE: begin
        if (telemetry_ok) begin
          has_result = 1'b1;
          if (st.expired || st.braking) begin
            if (below_trigger) begin
              // release: a held brake current is dropped with a zero motor current
              cmd.kind = (st.brake_current != '0) ? mdsb_pkg::KIND_CURRENT
                                                  : mdsb_pkg::KIND_BRAKE;
            end else begin
              st_next.brake_current = brake_next;
              cmd.kind = mdsb_pkg::KIND_BRAKE;
              cmd.current = brake_next;
            end
          end else if (tgt == '0) begin
            cmd.kind = mdsb_pkg::KIND_CURRENT;
          end else begin
            cmd.kind = mdsb_pkg::KIND_DUTY;
            cmd.duty = duty_clamp[mdsb_pkg::DUTY_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/motor_duty_step_and_brake_controller_core.sv
// top level of the motor duty step and brake controller
// Usage:
// - input channel (in_valid/in_ready) takes one word per cycle while in_ready is
//   high: an action code with target_erpm, measured_erpm, present_duty and telemetry_ok
// - set-target, brake and tick words only change internal state and give no result
// - an update word with telemetry_ok high gives exactly one command word on the
//   output channel (out_valid/out_ready): command_kind, duty_value, current_ma
// - a word accepted into the input register is evaluated there; when it fires, the
//   output registers load its command, from which the receiver can take it
// - throughput: one word per cycle unless an update waits on a stalled output; the
//   evaluation stage compares, adds and clamps against the control state
//   combinationally, so each word sees the state that the previous word left
// - when the receiver stalls, the held command stays in the output register; words
//   that give no result keep flowing, and the first update behind the stall waits
//   in the evaluation stage, which then holds in_ready low
// - reset: the configuration registers take their default values, the target is
//   zero, braking mode is on and the safety timer counts as expired
// - configuration writes (cfg_write, cfg_index, cfg_data) take effect at the edge
//   and are expected while the block is idle; unknown indexes are ignored
module motor_duty_step_and_brake_controller_core #(
  parameter int SPEED_WIDTH = mdsb_pkg::SPEED_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mdsb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mdsb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         action,
  input  logic signed [mdsb_pkg::ERPM_W-1:0] target_erpm,
  input  logic signed [mdsb_pkg::ERPM_W-1:0] measured_erpm,
  input  logic signed [mdsb_pkg::DUTY_W-1:0] present_duty,
  input  logic                               telemetry_ok,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         command_kind,
  output logic signed [mdsb_pkg::DUTY_W-1:0] duty_value,
  output logic [mdsb_pkg::CUR_W-1:0]         current_ma
);

  mdsb_pkg::cfg_t cfg;
  mdsb_pkg::ctl_state_t st;
  mdsb_pkg::ctl_state_t st_next;
  mdsb_pkg::cmd_t cmd;
  logic signed [SPEED_WIDTH-1:0] tgt;
  logic signed [SPEED_WIDTH-1:0] tgt_next;

  // input register
  logic                               s1_valid;
  logic [1:0]                         s1_action;
  logic signed [mdsb_pkg::ERPM_W-1:0] s1_target;
  logic signed [mdsb_pkg::ERPM_W-1:0] s1_measured;
  logic signed [mdsb_pkg::DUTY_W-1:0] s1_duty;
  logic                               s1_ok;

  logic has_result;
  logic out_free;
  logic fire;

  mdsb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdsb_eval #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_eval (
    .action        (s1_action),
    .target_erpm   (s1_target),
    .measured_erpm (s1_measured),
    .present_duty  (s1_duty),
    .telemetry_ok  (s1_ok),
    .cfg           (cfg),
    .st            (st),
    .tgt           (tgt),
    .st_next       (st_next),
    .tgt_next      (tgt_next),
    .has_result    (has_result),
    .cmd           (cmd)
  );

  assign out_free = !out_valid || out_ready;
  // words without a result never wait on the output side
  assign fire     = s1_valid && (!has_result || out_free);
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action   <= action;
      s1_target   <= target_erpm;
      s1_measured <= measured_erpm;
      s1_duty     <= present_duty;
      s1_ok       <= telemetry_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.braking       <= 1'b1;
      st.brake_current <= '0;
      st.elapsed       <= '0;
      st.expired       <= 1'b1;
      tgt              <= '0;
    end else if (fire) begin
      st  <= st_next;
      tgt <= tgt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      command_kind <= cmd.kind;
      duty_value   <= cmd.duty;
      current_ma   <= cmd.current;
    end
  end

endmodule
